>>> rtl/lft_pkg.sv
// Shared types and constants for the learning forwarding table.
// Holds the result action codes and the classifier port codes.
// No dependencies.
package lft_pkg;

   typedef logic [1:0] action_type;
   typedef logic [2:0] class_port_type;
   typedef logic [1:0] router_port_type;

   localparam action_type ACT_ACK     = 2'd0;
   localparam action_type ACT_FORWARD = 2'd1;
   localparam action_type ACT_MISS    = 2'd2;
   localparam action_type ACT_UNKNOWN = 2'd3;

   localparam class_port_type PORT_DATA_0  = 3'd0;
   localparam class_port_type PORT_HELLO_0 = 3'd1;
   localparam class_port_type PORT_DATA_1  = 3'd2;
   localparam class_port_type PORT_HELLO_1 = 3'd3;
   localparam class_port_type PORT_DATA_2  = 3'd4;
   localparam class_port_type PORT_HELLO_2 = 3'd5;

   localparam int REQ_ADDRESS_BITS = 8;

endpackage

>>> rtl/learning_forwarding_table.sv
// Top level of the learning forwarding table: a content-addressed table of
// learned addresses with their next hops, fed by hello and data transactions.
// Depends on lft_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_in_port, req_address
//   rsp      out        rsp_valid/rsp_stall  rsp_action, rsp_out_port, rsp_table_full
//
// Each transaction passes through the input register and then the result register,
// and a new one is accepted every cycle unless req_stall is raised; the parallel compare of all entries sets the path.
// Reset empties the table by clearing the fill count, with no clearing pass.
// A stall on the result side holds the input register, which then stalls req.
module learning_forwarding_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int ADDR_BITS   = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lft_pkg::class_port_type          req_in_port,
   input  logic [lft_pkg::REQ_ADDRESS_BITS-1:0] req_address,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lft_pkg::action_type              rsp_action,
   output lft_pkg::router_port_type         rsp_out_port,
   output logic                             rsp_table_full
);
   import lft_pkg::*;

   localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [ADDR_BITS-1:0]  key_in;
   logic                  s1_valid_ff;
   class_port_type        s1_port_ff;
   logic [ADDR_BITS-1:0]  s1_key_ff;

   logic [ADDR_BITS-1:0]  entry_address_ff [TABLE_DEPTH];
   router_port_type       entry_next_hop_ff [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] entry_count_ff;
   logic [COUNT_BITS-1:0] entry_count_in;

   logic                  rsp_valid_ff;
   action_type            rsp_action_ff;
   router_port_type       rsp_out_port_ff;
   logic                  rsp_table_full_ff;
   action_type            rsp_action_in;
   router_port_type       rsp_out_port_in;
   logic                  rsp_table_full_in;

   logic                  advance;
   logic                  hit;
   router_port_type       hit_hop;
   logic                  is_hello;
   logic                  is_data;
   logic                  has_room;
   logic                  learn;

   generate
      if (ADDR_BITS >= REQ_ADDRESS_BITS) begin : g_key_wide
         assign key_in = ADDR_BITS'(req_address);
      end else begin : g_key_narrow
         assign key_in = req_address[ADDR_BITS-1:0];
      end
   endgenerate

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   always_comb begin
      hit     = 1'b0;
      hit_hop = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if ((COUNT_BITS'(i) < entry_count_ff) && (entry_address_ff[i] == s1_key_ff)) begin
            hit     = 1'b1;
            hit_hop = hit_hop | entry_next_hop_ff[i];
         end
      end
   end

   always_comb begin
      is_hello = (s1_port_ff == PORT_HELLO_0) || (s1_port_ff == PORT_HELLO_1) ||
                 (s1_port_ff == PORT_HELLO_2);
      is_data  = (s1_port_ff == PORT_DATA_0) || (s1_port_ff == PORT_DATA_1) ||
                 (s1_port_ff == PORT_DATA_2);
      has_room = entry_count_ff < COUNT_BITS'(TABLE_DEPTH);
      learn    = s1_valid_ff && advance && is_hello && !hit && has_room;
      entry_count_in    = learn ? entry_count_ff + COUNT_BITS'(1) : entry_count_ff;
      rsp_action_in     = ACT_UNKNOWN;
      rsp_out_port_in   = '0;
      rsp_table_full_in = 1'b0;
      if (is_hello) begin
         rsp_action_in     = ACT_ACK;
         rsp_out_port_in   = s1_port_ff[2:1];
         rsp_table_full_in = !hit && !has_room;
      end else if (is_data) begin
         if (hit) begin
            rsp_action_in   = ACT_FORWARD;
            rsp_out_port_in = hit_hop;
         end else begin
            rsp_action_in   = ACT_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         entry_count_ff <= entry_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_port_ff <= req_in_port;
         s1_key_ff  <= key_in;
      end
      if (advance && s1_valid_ff) begin
         rsp_action_ff     <= rsp_action_in;
         rsp_out_port_ff   <= rsp_out_port_in;
         rsp_table_full_ff <= rsp_table_full_in;
      end
      if (learn) begin
         entry_address_ff[entry_count_ff[IDX_BITS-1:0]]  <= s1_key_ff;
         entry_next_hop_ff[entry_count_ff[IDX_BITS-1:0]] <= s1_port_ff[2:1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_out_port   = rsp_out_port_ff;
   assign rsp_table_full = rsp_table_full_ff;

endmodule

>>> bench/tb_learning_forwarding_table.sv
// Self-checking testbench for learning_forwarding_table: hello and data headers
// go in on the req channel and every rsp transaction is checked against a model.
// Depends on lft_pkg and the learning_forwarding_table RTL.
`timescale 1ns / 1ps

module tb_learning_forwarding_table;
   import lft_pkg::*;

   localparam int TABLE_ENTRIES = 16;
   localparam int RANDOM_HEADERS = 700;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_LIMIT = 10;

   localparam class_port_type PORT_UNKNOWN_0 = 3'd6;
   localparam class_port_type PORT_UNKNOWN_1 = 3'd7;

   localparam class_port_type HELLO_PORTS [3] = '{PORT_HELLO_0, PORT_HELLO_1, PORT_HELLO_2};
   localparam class_port_type DATA_PORTS [3] = '{PORT_DATA_0, PORT_DATA_1, PORT_DATA_2};
   localparam class_port_type UNKNOWN_PORTS [2] = '{PORT_UNKNOWN_0, PORT_UNKNOWN_1};

   typedef struct packed {
      action_type      action;
      router_port_type out_port;
      logic            table_full;
   } lft_result_type;

   class forwarding_scoreboard;
      logic [7:0]      learned_addr [TABLE_ENTRIES];
      router_port_type learned_hop [TABLE_ENTRIES];
      int              entry_total;
      lft_result_type  expected_results [$];
      int              mismatches;
      int              checked;
      int              acks;
      int              full_acks;
      int              forwards;
      int              misses;
      int              unknowns;

      function new();
         entry_total = 0;
         mismatches = 0;
         checked = 0;
         acks = 0;
         full_acks = 0;
         forwards = 0;
         misses = 0;
         unknowns = 0;
      endfunction

      function bit lookup(logic [7:0] addr, output int idx);
         int i;
         idx = 0;
         for (i = 0; i < entry_total; i++) begin
            if (learned_addr[i] == addr) begin
               idx = i;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function logic [7:0] pick_learned();
         if (entry_total == 0) begin
            return 8'($urandom);
         end
         return learned_addr[$urandom_range(0, entry_total - 1)];
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_header(class_port_type port, logic [7:0] addr);
         lft_result_type want;
         int             idx;
         want = '0;
         case (port)
            PORT_HELLO_0, PORT_HELLO_1, PORT_HELLO_2: begin
               want.action = ACT_ACK;
               want.out_port = router_port_type'(port >> 1);
               if (!lookup(addr, idx)) begin
                  if (entry_total < TABLE_ENTRIES) begin
                     learned_addr[entry_total] = addr;
                     learned_hop[entry_total] = want.out_port;
                     entry_total++;
                  end else begin
                     want.table_full = 1'b1;
                     full_acks++;
                  end
               end
               acks++;
            end
            PORT_DATA_0, PORT_DATA_1, PORT_DATA_2: begin
               if (lookup(addr, idx)) begin
                  want.action = ACT_FORWARD;
                  want.out_port = learned_hop[idx];
                  forwards++;
               end else begin
                  want.action = ACT_MISS;
                  misses++;
               end
            end
            default: begin
               want.action = ACT_UNKNOWN;
               unknowns++;
            end
         endcase
         expected_results.insert(expected_results.size(), want);
      endfunction

      function void report(string what, lft_result_type want, lft_result_type got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s: expected action %0d port %0d full %0d,",
                     $realtime, what, want.action, want.out_port, want.table_full);
            $display("   got action %0d port %0d full %0d",
                     got.action, got.out_port, got.table_full);
         end
      endfunction

      function void check_result(lft_result_type got);
         lft_result_type want;
         if (expected_results.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         want = expected_results.pop_front();
         checked++;
         if (got.action !== want.action || got.out_port !== want.out_port ||
             got.table_full !== want.table_full) begin
            report("result mismatch", want, got);
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   class_port_type  req_in_port;
   logic [REQ_ADDRESS_BITS-1:0] req_address;
   logic            rsp_valid;
   logic            rsp_stall;
   action_type      rsp_action;
   router_port_type rsp_out_port;
   logic            rsp_table_full;

   forwarding_scoreboard sb;
   bit  hold_rsp_req = 1'b0;
   bit  req_offered = 1'b0;
   int  cycle_count = 0;

   learning_forwarding_table #(
      .TABLE_DEPTH(TABLE_ENTRIES),
      .ADDR_BITS  (REQ_ADDRESS_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_port   (req_in_port),
      .req_address   (req_address),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_action    (rsp_action),
      .rsp_out_port  (rsp_out_port),
      .rsp_table_full(rsp_table_full)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("[learning_forwarding_table] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(lft_result_type'{rsp_action, rsp_out_port, rsp_table_full});
         end
         if (req_valid && !req_stall) begin
            sb.note_header(req_in_port, req_address);
         end
      end
   end

   // The receiver alternates stalled and free stretches, and on request holds
   // off for a long stretch so that the block fills up and stalls its input.
   initial begin : receiver
      int pick;
      int span;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_rsp_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp_req = 1'b0;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(1, 4);
            end else if (pick < 8) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(1, 3);
            end else if (pick == 8) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(15, 40);
            end else begin
               rsp_stall <= 1'b0;
               span = $urandom_range(20, 60);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 30);
   endfunction

   task automatic send_header(class_port_type port, logic [7:0] addr);
      int gap;
      req_valid <= 1'b1;
      req_in_port <= port;
      req_address <= addr;
      req_offered = 1'b1;
      do @(posedge clock); while (req_stall);
      gap = hold_rsp_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      if (req_offered) begin
         req_valid <= 1'b0;
         req_offered = 1'b0;
      end
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random_header();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         send_header(DATA_PORTS[$urandom_range(0, 2)],
                     ($urandom_range(0, 99) < 65) ? sb.pick_learned() : 8'($urandom));
      end else if (pick < 85) begin
         send_header(HELLO_PORTS[$urandom_range(0, 2)],
                     ($urandom_range(0, 1) == 1) ? sb.pick_learned() : 8'($urandom));
      end else begin
         send_header(UNKNOWN_PORTS[$urandom_range(0, 1)], 8'($urandom));
      end
   endtask

   initial begin : stimulus
      int i;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_port <= PORT_DATA_0;
      req_address <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty table first: a data miss and both unknown ports.
      send_header(PORT_DATA_0, 8'h00);
      send_header(PORT_UNKNOWN_1, 8'hFF);
      send_header(PORT_UNKNOWN_0, 8'h00);
      // Learn on each hello port, then hit each entry once, each from a different data port.
      send_header(PORT_HELLO_0, 8'h00);
      send_header(PORT_HELLO_1, 8'hFF);
      send_header(PORT_HELLO_2, 8'h5A);
      send_header(PORT_DATA_1, 8'hFF);
      send_header(PORT_DATA_2, 8'h00);
      send_header(PORT_DATA_0, 8'h5A);
      // A known address learned again on another port keeps its next hop.
      send_header(PORT_HELLO_2, 8'h00);
      send_header(PORT_DATA_2, 8'h00);
      // Fill the table, then offer a new address that no longer fits.
      for (i = 0; i < TABLE_ENTRIES - 3; i++) begin
         send_header(HELLO_PORTS[i % 3], 8'(8'h10 + i * 8'h0D));
      end
      send_header(PORT_HELLO_1, 8'hA5);
      send_header(PORT_DATA_1, 8'hA5);

      for (i = 0; i < RANDOM_HEADERS; i++) begin
         if (i == 150) begin
            hold_rsp_req = 1'b1;
         end
         if (i == 400 || i == 600) begin
            drain_results();
         end
         send_random_header();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d transactions: %0d acks (%0d with the table full), %0d forwards,",
               sb.checked, sb.acks, sb.full_acks, sb.forwards);
      $display("%0d misses and %0d unknown ports; %0d mismatches.",
               sb.misses, sb.unknowns, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[learning_forwarding_table] OK");
      end else begin
         $display("[learning_forwarding_table] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/lft_pkg.sv
rtl/learning_forwarding_table.sv
bench/tb_learning_forwarding_table.sv
